// ----- rtl/spq_pkg.sv -----
package spq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_HEAD = 2'd1,
    SEL_IDX  = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_word_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic            insert;
    logic            remove;
    logic            load_out;
    out_sel_e        out_sel;
    status_e         status;
    logic            last;
    logic [IdxW-1:0] rd_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [CntW-1:0] count;
  } dp_sts_t;

endpackage

// ----- rtl/spq_dp.sv -----
module spq_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::entry_t     entry_i,
  input  spq_pkg::dp_cmd_t    cmd_i,
  output spq_pkg::dp_sts_t    sts_o,
  output spq_pkg::out_word_t  out_word_o
);
  import spq_pkg::*;

  entry_t          entries_q [Depth];
  logic [CntW-1:0] count_q, count_d;
  logic [Depth-1:0] ge;
  out_word_t       out_q, out_d;

  // Entries at or above the new priority stay; the list is sorted, so this is a thermometer.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ge[i] = (CntW'(i) < count_q) && (entries_q[i].prio >= entry_i.prio);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (cmd_i.insert && !ge[i]) begin
        if (i == 0) begin
          entries_q[i] <= entry_i;
        end else if (ge[(i == 0) ? 0 : i - 1]) begin
          entries_q[i] <= entry_i;
        end else begin
          entries_q[i] <= entries_q[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd_i.remove && (i < Depth - 1)) begin
        entries_q[i] <= entries_q[(i < Depth - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    out_d        = out_q;
    if (cmd_i.load_out) begin
      out_d.status = cmd_i.status;
      out_d.last   = cmd_i.last;
      unique case (cmd_i.out_sel)
        SEL_HEAD: begin
          out_d.out_value    = entries_q[0].value;
          out_d.out_priority = entries_q[0].prio;
        end
        SEL_IDX: begin
          out_d.out_value    = entries_q[cmd_i.rd_idx].value;
          out_d.out_priority = entries_q[cmd_i.rd_idx].prio;
        end
        default: begin
          out_d.out_value    = '0;
          out_d.out_priority = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.count = count_q;
  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CntW'(Depth));
  assign out_word_o  = out_q;

endmodule

// ----- rtl/spq_ctrl.sv -----
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spq_pkg::dp_sts_t  sts_i,
  output spq_pkg::dp_cmd_t  cmd_o
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic            state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;
  logic            accept;
  logic            idx_last;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign idx_last   = ({1'b0, idx_q} + CntW'(1)) == sts_i.count;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.out_sel = SEL_ZERO;
    cmd_o.status  = ST_OK;
    cmd_o.rd_idx  = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (cmd_i == CMD_ENQ) begin
            cmd_o.load_out = 1'b1;
            cmd_o.last     = 1'b1;
            cmd_o.status   = sts_i.full ? ST_FULL : ST_OK;
            cmd_o.insert   = !sts_i.full;
          end else if (cmd_i == CMD_DEQ) begin
            cmd_o.load_out = 1'b1;
            cmd_o.last     = 1'b1;
            cmd_o.status   = sts_i.empty ? ST_EMPTY : ST_OK;
            cmd_o.out_sel  = sts_i.empty ? SEL_ZERO : SEL_HEAD;
            cmd_o.remove   = !sts_i.empty;
          end else if (cmd_i == CMD_READ) begin
            if (sts_i.empty) begin
              cmd_o.load_out = 1'b1;
              cmd_o.last     = 1'b1;
              cmd_o.status   = ST_EMPTY;
            end else begin
              idx_d   = '0;
              state_d = S_READ;
            end
          end else begin
          end
        end
      end
      S_READ: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = SEL_IDX;
          cmd_o.last     = idx_last;
          idx_d          = idx_q + IdxW'(1);
          if (idx_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ({1'b0, idx_q} < sts_i.count))
    else $error("read-out index beyond stored entries");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.insert |-> !sts_i.full)
    else $error("insert into a full store");

  a_no_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.remove |-> !sts_i.empty)
    else $error("remove from an empty store");

  a_load_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> slot_free)
    else $error("output word overwritten before it was taken");

endmodule

// ----- rtl/stable_priority_queue.sv -----
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_ready_o  | spq_pkg::in_word_t in_word_i
// out     | output    | out_valid_o / out_ready_i | spq_pkg::out_word_t out_word_o
//
// Enqueue inserts through a parallel compare over all entries; dequeue shifts the rest up.
// Read-out enters S_READ, then emits one word per cycle per stored entry unless stalled.
// A new command is taken when idle and the output register is free or being drained.
// Reset clears the entry count and control state; entry storage needs no reset.
// Backpressure on the output stalls read-out and holds off the input channel.
module stable_priority_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spq_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spq_pkg::out_word_t  out_word_o
);
  import spq_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  entry_t  new_entry;

  assign new_entry.value = in_word_i.item_value;
  assign new_entry.prio  = in_word_i.item_priority;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (in_word_i.cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  spq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (new_entry),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_word_o (out_word_o)
  );

endmodule
